FILE: design/tknp_pkg.sv
// Shared constants, types and codes for the top-k nearest points block.
package tknp_pkg;

    localparam int LIST_DEPTH  = 8;
    localparam int MAX_RESULTS = 8;
    localparam int COUNT_W     = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W       = $clog2(LIST_DEPTH);

    localparam int TAG_W      = 16;
    localparam int COORD_W    = 16;
    localparam int CONF_W     = 8;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * COORD_W;     // (2^16-1)^2 fits 32 bits
    localparam int DIST_W     = SQ_W + 1;
    localparam int OUT_DIST_W = 36;
    localparam int RANK_W     = 3;
    localparam int KEEP_W     = 4;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(8);

    typedef enum logic [1:0] {
        REG_REF_X      = 2'd0,
        REG_REF_Y      = 2'd1,
        REG_KEEP_COUNT = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_INSERT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [DIST_W-1:0]  dsq;
        logic [TAG_W-1:0]   tag;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CONF_W-1:0]  conf;
    } entry_t;

    typedef struct packed {
        logic             capture;
        logic             square;
        logic             sum;
        logic             insert;
        logic             emit;
        logic [IDX_W-1:0] emit_idx;
        logic             final_entry;
        logic             clear;
    } dp_cmd_t;

    typedef struct packed {
        logic               last_point;
        logic [COUNT_W-1:0] held_count;
        logic               out_free;
    } dp_stat_t;

endpackage

FILE: design/tknp_ctrl.sv
// Sequencer: steps one point through square, sum and insert, and after a batch-end point reads out the list.
module tknp_ctrl import tknp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [KEEP_W-1:0] keep_count,
    input  dp_stat_t          stat,
    output dp_cmd_t           cmd
);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [COUNT_W-1:0] keep_eff;
    logic [COUNT_W-1:0] report_n;
    logic               is_final;

    // number of entries to report: min(keep_count, 8, held)
    always_comb begin
        keep_eff = (keep_count > KEEP_W'(MAX_RESULTS)) ? COUNT_W'(MAX_RESULTS)
                                                        : COUNT_W'(keep_count);
        report_n = (keep_eff < stat.held_count) ? keep_eff : stat.held_count;
        is_final = (COUNT_W'(idx_reg) + COUNT_W'(1)) == report_n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_SQUARE;
            end
            ST_SQUARE: state_next = ST_SUM;
            ST_SUM:    state_next = ST_INSERT;
            ST_INSERT: begin
                state_next = stat.last_point ? ST_EMIT : ST_IDLE;
                idx_next   = '0;
            end
            ST_EMIT: begin
                if (report_n == '0) begin
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    if (is_final) begin
                        state_next = ST_IDLE;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd             = '0;
        cmd.emit_idx    = idx_reg;
        cmd.final_entry = is_final;
        s_ready         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_SQUARE: cmd.square = 1'b1;
            ST_SUM:    cmd.sum    = 1'b1;
            ST_INSERT: cmd.insert = 1'b1;
            ST_EMIT: begin
                cmd.emit  = (report_n != '0) && stat.out_free;
                cmd.clear = (report_n == '0) || (stat.out_free && is_final);
            end
            default: ;
        endcase
    end

endmodule

FILE: design/tknp_dpath.sv
// Datapath: distance arithmetic, sorted list of held points, result register.
module tknp_dpath import tknp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic [COORD_W-1:0]    ref_x,
    input  logic [COORD_W-1:0]    ref_y,
    input  logic [TAG_W-1:0]      s_point_tag,
    input  logic [COORD_W-1:0]    s_pos_x,
    input  logic [COORD_W-1:0]    s_pos_y,
    input  logic [CONF_W-1:0]     s_confidence,
    input  logic                  s_batch_end,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [TAG_W-1:0]      m_out_tag,
    output logic [COORD_W-1:0]    m_out_x,
    output logic [COORD_W-1:0]    m_out_y,
    output logic [CONF_W-1:0]     m_out_confidence,
    output logic [OUT_DIST_W-1:0] m_out_dist_sq,
    output logic [RANK_W-1:0]     m_rank,
    output logic                  m_final_entry
);

    logic [TAG_W-1:0]   in_tag_reg;
    logic [COORD_W-1:0] in_x_reg;
    logic [COORD_W-1:0] in_y_reg;
    logic [CONF_W-1:0]  in_conf_reg;
    logic               in_last_reg;

    logic signed [DIFF_W-1:0]   dx, dy;
    logic signed [2*DIFF_W-1:0] prod_x, prod_y;
    logic [SQ_W-1:0]            sq_x_reg, sq_y_reg;
    logic [DIST_W-1:0]          dist_reg;

    entry_t             held_reg  [LIST_DEPTH];
    entry_t             held_next [LIST_DEPTH];
    entry_t             shift_src [LIST_DEPTH];
    entry_t             new_entry;
    logic [LIST_DEPTH-1:0] ins;
    logic [LIST_DEPTH-1:0] ins_prev;
    logic [COUNT_W-1:0] count_reg;

    entry_t             out_reg;
    logic [RANK_W-1:0]  rank_reg;
    logic               final_reg;
    logic               m_valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_tag_reg  <= s_point_tag;
            in_x_reg    <= s_pos_x;
            in_y_reg    <= s_pos_y;
            in_conf_reg <= s_confidence;
            in_last_reg <= s_batch_end;
        end
    end

    // squares: 17-bit signed difference, one multiplier per axis
    always_comb begin
        dx     = $signed({in_x_reg[COORD_W-1], in_x_reg}) - $signed({ref_x[COORD_W-1], ref_x});
        dy     = $signed({in_y_reg[COORD_W-1], in_y_reg}) - $signed({ref_y[COORD_W-1], ref_y});
        prod_x = dx * dx;
        prod_y = dy * dy;
    end

    always_ff @(posedge aclk) begin
        if (cmd.square) begin
            sq_x_reg <= prod_x[SQ_W-1:0];
            sq_y_reg <= prod_y[SQ_W-1:0];
        end
        if (cmd.sum) begin
            dist_reg <= {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
        end
    end

    // insertion: every held entry compares against the new key at once;
    // the insert flags rise monotonically along the sorted list
    always_comb begin
        new_entry.dsq  = dist_reg;
        new_entry.tag  = in_tag_reg;
        new_entry.x    = in_x_reg;
        new_entry.y    = in_y_reg;
        new_entry.conf = in_conf_reg;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            ins[i] = (COUNT_W'(i) >= count_reg)
                  || (dist_reg < held_reg[i].dsq)
                  || ((dist_reg == held_reg[i].dsq) && (in_tag_reg < held_reg[i].tag));
        end
        ins_prev     = {ins[LIST_DEPTH-2:0], 1'b0};
        shift_src[0] = new_entry;
        for (int i = 1; i < LIST_DEPTH; i++) begin
            shift_src[i] = held_reg[i-1];
        end
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (ins[i] && !ins_prev[i]) begin
                held_next[i] = new_entry;
            end else if (ins[i]) begin
                held_next[i] = shift_src[i];
            end else begin
                held_next[i] = held_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            for (int i = 0; i < LIST_DEPTH; i++) begin
                held_reg[i] <= held_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.clear) begin
            count_reg <= '0;
        end else if (cmd.insert && (count_reg < COUNT_W'(LIST_DEPTH))) begin
            count_reg <= count_reg + COUNT_W'(1);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg   <= held_reg[cmd.emit_idx];
            rank_reg  <= RANK_W'(cmd.emit_idx);
            final_reg <= cmd.final_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign stat.last_point = in_last_reg;
    assign stat.held_count = count_reg;
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_out_tag        = out_reg.tag;
    assign m_out_x          = out_reg.x;
    assign m_out_y          = out_reg.y;
    assign m_out_confidence = out_reg.conf;
    assign m_out_dist_sq    = OUT_DIST_W'(out_reg.dsq);
    assign m_rank           = rank_reg;
    assign m_final_entry    = final_reg;

endmodule

FILE: design/top_k_nearest_points.sv
// Top level: keeps the nearest points of a batch and reports them in rank order.
//
//  channel  | handshake        | beat
//  ---------+------------------+-------------------------------------------------
//  s_       | s_valid/s_ready  | one point: tag, x, y, confidence, batch end
//  m_       | m_valid/m_ready  | one reported entry: tag, x, y, conf, dist, rank
//  apb      | psel/penable     | ref_x @0x0, ref_y @0x4, keep_count @0x8
//
// A point goes through accept, square (one 17x17 multiplier per axis), sum,
// then a parallel compare-and-shift insert into the eight-entry list.
// After a batch-end point the list is read out one entry per cycle; m_ready
// low holds the sequencer, and the input stays closed until readout is over.
// The result register lets the input reopen as soon as the last beat is loaded.
// aresetn (synchronous) empties the list and loads the register defaults.
module top_k_nearest_points import tknp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // point input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [TAG_W-1:0]      s_point_tag,
    input  logic [COORD_W-1:0]    s_pos_x,
    input  logic [COORD_W-1:0]    s_pos_y,
    input  logic [CONF_W-1:0]     s_confidence,
    input  logic                  s_batch_end,
    // report output
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [TAG_W-1:0]      m_out_tag,
    output logic [COORD_W-1:0]    m_out_x,
    output logic [COORD_W-1:0]    m_out_y,
    output logic [CONF_W-1:0]     m_out_confidence,
    output logic [OUT_DIST_W-1:0] m_out_dist_sq,
    output logic [RANK_W-1:0]     m_rank,
    output logic                  m_final_entry,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    logic [COORD_W-1:0] ref_x_reg;
    logic [COORD_W-1:0] ref_y_reg;
    logic [KEEP_W-1:0]  keep_count_reg;
    logic               reg_wr;
    cfg_reg_t           reg_sel;

    dp_cmd_t  ctrl_cmd;
    dp_stat_t dp_stat;

    // register file: word address selects the register, top index unused
    assign pready  = 1'b1;
    assign reg_wr  = psel && penable && pwrite;
    assign reg_sel = cfg_reg_t'(paddr[APB_AW-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_x_reg      <= '0;
            ref_y_reg      <= '0;
            keep_count_reg <= KEEP_RESET;
        end else if (reg_wr) begin
            unique case (reg_sel)
                REG_REF_X:      ref_x_reg      <= pwdata[COORD_W-1:0];
                REG_REF_Y:      ref_y_reg      <= pwdata[COORD_W-1:0];
                REG_KEEP_COUNT: keep_count_reg <= pwdata[KEEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_REF_X:      prdata = APB_DW'(ref_x_reg);
            REG_REF_Y:      prdata = APB_DW'(ref_y_reg);
            REG_KEEP_COUNT: prdata = APB_DW'(keep_count_reg);
            default:        prdata = '0;
        endcase
    end

    tknp_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .keep_count (keep_count_reg),
        .stat       (dp_stat),
        .cmd        (ctrl_cmd)
    );

    tknp_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (ctrl_cmd),
        .stat             (dp_stat),
        .ref_x            (ref_x_reg),
        .ref_y            (ref_y_reg),
        .s_point_tag      (s_point_tag),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_confidence     (s_confidence),
        .s_batch_end      (s_batch_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_tag        (m_out_tag),
        .m_out_x          (m_out_x),
        .m_out_y          (m_out_y),
        .m_out_confidence (m_out_confidence),
        .m_out_dist_sq    (m_out_dist_sq),
        .m_rank           (m_rank),
        .m_final_entry    (m_final_entry)
    );

`ifndef NO_ASSERTIONS
    // a point in flight closes the input until its insert is done
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted again while a point was in flight");

    // list never holds more than its depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_stat.held_count <= COUNT_W'(LIST_DEPTH))
        else $error("held count beyond list depth");

    // loading the final beat empties the list
    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.emit && ctrl_cmd.final_entry |=> dp_stat.held_count == '0)
        else $error("list not emptied after final beat");

    // no result is loaded over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.emit |-> (!m_valid || m_ready))
        else $error("result register overwritten while stalled");
`endif

endmodule

FILE: tb/sv/top_k_nearest_points_tb.sv
// Self-checking testbench for the top-k nearest points block.
module top_k_nearest_points_tb;
    import tknp_pkg::*;

    localparam int RAND_ITEMS   = 410;
    localparam int DRAIN_CYCLES = 12;      // a point passes square, sum and insert before it settles in the list
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_AT      = 60;      // report beat after which the sink holds off
    localparam int HOLD_CYCLES  = 400;
    localparam int N_DIR        = 35;

    // index 3 decodes to no register
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum logic { ROW_POINT, ROW_WRITE } row_kind_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CONF_W-1:0]  conf;
        logic               last;
    } point_t;

    typedef struct packed {
        logic [OUT_DIST_W-1:0] dsq;
        logic [TAG_W-1:0]      tag;
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic [CONF_W-1:0]     conf;
    } held_t;

    typedef struct packed {
        logic [TAG_W-1:0]      tag;
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic [CONF_W-1:0]     conf;
        logic [OUT_DIST_W-1:0] dsq;
        logic [RANK_W-1:0]     rank;
        logic                  fin;
    } report_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [1:0]            reg_idx;
        logic [15:0]           cfg_val;
        point_t                pnt;
        logic                  typed;     // expected report written in the row
        logic [OUT_DIST_W-1:0] exp_dist;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [TAG_W-1:0]      s_point_tag;
    logic [COORD_W-1:0]    s_pos_x;
    logic [COORD_W-1:0]    s_pos_y;
    logic [CONF_W-1:0]     s_confidence;
    logic                  s_batch_end;
    logic                  m_valid;
    logic                  m_ready;
    logic [TAG_W-1:0]      m_out_tag;
    logic [COORD_W-1:0]    m_out_x;
    logic [COORD_W-1:0]    m_out_y;
    logic [CONF_W-1:0]     m_out_confidence;
    logic [OUT_DIST_W-1:0] m_out_dist_sq;
    logic [RANK_W-1:0]     m_rank;
    logic                  m_final_entry;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    // predictor state: register copies and the sorted list
    logic signed [COORD_W-1:0] cfg_ref_x;
    logic signed [COORD_W-1:0] cfg_ref_y;
    logic [KEEP_W-1:0]         cfg_keep;
    held_t                     near_list [LIST_DEPTH];
    int                        list_len;

    report_t report_q [$];
    int      mismatches = 0;
    int      beats_seen = 0;
    bit      tx_burst   = 0;
    bit      rx_burst   = 0;
    dir_row_t dir_tab [N_DIR];

    top_k_nearest_points DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_point_tag      (s_point_tag),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_confidence     (s_confidence),
        .s_batch_end      (s_batch_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_tag        (m_out_tag),
        .m_out_x          (m_out_x),
        .m_out_y          (m_out_y),
        .m_out_confidence (m_out_confidence),
        .m_out_dist_sq    (m_out_dist_sq),
        .m_rank           (m_rank),
        .m_final_entry    (m_final_entry),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Insert one point into the sorted list; on batch end, queue the reports if emit is set and empty the list.
    function automatic void predict_point(point_t p, bit emit);
        longint                dx;
        longint                dy;
        logic [OUT_DIST_W-1:0] d;
        int                    pos;
        int                    tail;
        int                    n;
        dx = longint'($signed(p.x)) - longint'(cfg_ref_x);
        dy = longint'($signed(p.y)) - longint'(cfg_ref_y);
        d  = OUT_DIST_W'(dx * dx + dy * dy);
        // equal keys: the newcomer goes after the held entry
        pos = 0;
        while (pos < list_len && (d > near_list[pos].dsq ||
               (d == near_list[pos].dsq && p.tag >= near_list[pos].tag)))
            pos++;
        if (pos < LIST_DEPTH) begin
            tail = (list_len < LIST_DEPTH) ? list_len : LIST_DEPTH - 1;
            for (int i = tail; i > pos; i--)
                near_list[i] = near_list[i-1];
            near_list[pos] = '{d, p.tag, p.x, p.y, p.conf};
            if (list_len < LIST_DEPTH)
                list_len++;
        end
        if (p.last) begin
            n = int'(cfg_keep);
            if (n > list_len)
                n = list_len;
            if (n > MAX_RESULTS)
                n = MAX_RESULTS;
            if (emit) begin
                for (int k = 0; k < n; k++)
                    report_q.insert(report_q.size(),
                                    report_t'{near_list[k].tag, near_list[k].x,
                                              near_list[k].y, near_list[k].conf,
                                              near_list[k].dsq, RANK_W'(k), k + 1 == n});
            end
            list_len = 0;
        end
    endfunction

    function automatic void check_field(string name, logic [OUT_DIST_W-1:0] want,
                                        logic [OUT_DIST_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic dir_row_t pt(logic [15:0] tag, logic [15:0] x, logic [15:0] y,
                                    logic [7:0] conf, logic last);
        return '{ROW_POINT, 2'd0, 16'h0, '{tag, x, y, conf, last}, 1'b0, '0};
    endfunction

    // single-point batch whose one report can be read straight off the row
    function automatic dir_row_t pt_chk(logic [15:0] tag, logic [15:0] x, logic [15:0] y,
                                        logic [7:0] conf, logic [OUT_DIST_W-1:0] dsq);
        return '{ROW_POINT, 2'd0, 16'h0, '{tag, x, y, conf, 1'b1}, 1'b1, dsq};
    endfunction

    function automatic dir_row_t wr(logic [1:0] idx, logic [15:0] val);
        return '{ROW_WRITE, idx, val, '0, 1'b0, '0};
    endfunction

    // Offer one beat after a gap of idle cycles, then hold it until taken.
    task automatic push_point(point_t p, int gap, bit typed, logic [OUT_DIST_W-1:0] dsq);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_point_tag  <= p.tag;
        s_pos_x      <= p.x;
        s_pos_y      <= p.y;
        s_confidence <= p.conf;
        s_batch_end  <= p.last;
        do @(posedge aclk); while (!s_ready);
        predict_point(p, !typed);
        if (typed)
            report_q.insert(report_q.size(),
                            report_t'{p.tag, p.x, p.y, p.conf, dsq, '0, 1'b1});
    endtask

    // Stop sending, let every expected report drain, then let the pipeline settle.
    task automatic wait_idle();
        int spins;
        @(negedge aclk);
        s_valid <= 1'b0;
        spins = 0;
        while (report_q.size() != 0 && spins < IDLE_LIMIT) begin
            @(posedge aclk);
            spins++;
        end
        if (report_q.size() != 0) begin
            $error("%0d expected report beats never arrived", report_q.size());
            mismatches++;
            report_q.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [15:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= {16'h0, val};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_REF_X:      cfg_ref_x = val;
            REG_REF_Y:      cfg_ref_y = val;
            REG_KEEP_COUNT: cfg_keep  = val[KEEP_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result sink: random gaps per beat, bursts with none, one long hold-off
    initial begin
        int gap;
        forever begin
            gap = rx_burst ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_valid));
            beats_seen++;
            if (beats_seen % 16 == 0)
                rx_burst = ($urandom_range(0, 2) == 0);
            if (beats_seen == HOLD_AT) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (report_q.size() == 0) begin
                $error("unexpected report beat: tag 0x%0h rank %0d", m_out_tag, m_rank);
                mismatches++;
            end else begin
                want = report_q.pop_front();
                check_field("out_tag",        OUT_DIST_W'(want.tag),  OUT_DIST_W'(m_out_tag));
                check_field("out_x",          OUT_DIST_W'(want.x),    OUT_DIST_W'(m_out_x));
                check_field("out_y",          OUT_DIST_W'(want.y),    OUT_DIST_W'(m_out_y));
                check_field("out_confidence", OUT_DIST_W'(want.conf),
                            OUT_DIST_W'(m_out_confidence));
                check_field("out_dist_sq",    want.dsq,               m_out_dist_sq);
                check_field("rank",           OUT_DIST_W'(want.rank), OUT_DIST_W'(m_rank));
                check_field("final_entry",    OUT_DIST_W'(want.fin),
                            OUT_DIST_W'(m_final_entry));
            end
        end
    end

    initial begin
        point_t p;
        int     sent;
        int     batch_left;
        int     phase_len;
        int     mode;
        logic [15:0] pick;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_point_tag  = '0;
        s_pos_x      = '0;
        s_pos_y      = '0;
        s_confidence = '0;
        s_batch_end  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;

        cfg_ref_x = '0;
        cfg_ref_y = '0;
        cfg_keep  = KEEP_RESET;
        list_len  = 0;

        dir_tab = '{
            // reset values: reference at the origin, keep eight
            pt_chk(16'h0005, 16'h0100, 16'h0000, 8'h80, 36'h0_0001_0000),
            pt_chk(16'hFFFF, 16'h8000, 16'h8000, 8'hFF, 36'h0_8000_0000),
            // opposite corner: largest possible distance, then zero distance
            wr(REG_REF_X, 16'h7FFF),
            wr(REG_REF_Y, 16'h7FFF),
            pt_chk(16'h0000, 16'h8000, 16'h8000, 8'h00, 36'h1_FFFC_0002),
            pt_chk(16'hA5A5, 16'h7FFF, 16'h7FFF, 8'h5A, 36'h0),
            // equal distances: smaller tag first, equal keys in arrival order
            wr(REG_REF_X, 16'h0000),
            wr(REG_REF_Y, 16'h0000),
            pt(16'h0009, 16'h0100, 16'h0000, 8'h11, 1'b0),
            pt(16'h0002, 16'h0000, 16'h0100, 8'h22, 1'b0),
            pt(16'h0009, 16'hFF00, 16'h0000, 8'h33, 1'b0),
            pt(16'h0009, 16'h0000, 16'hFF00, 8'h44, 1'b1),
            // fill the list, offer one too far to fit, then a nearest one
            pt(16'h0001, 16'h0800, 16'h0000, 8'h01, 1'b0),
            pt(16'h0002, 16'h0700, 16'h0000, 8'h02, 1'b0),
            pt(16'h0003, 16'h0600, 16'h0000, 8'h03, 1'b0),
            pt(16'h0004, 16'h0500, 16'h0000, 8'h04, 1'b0),
            pt(16'h0005, 16'h0400, 16'h0000, 8'h05, 1'b0),
            pt(16'h0006, 16'h0300, 16'h0000, 8'h06, 1'b0),
            pt(16'h0007, 16'h0200, 16'h0000, 8'h07, 1'b0),
            pt(16'h0008, 16'h0100, 16'h0000, 8'h08, 1'b0),
            pt(16'h0014, 16'h7000, 16'h0000, 8'h14, 1'b0),
            pt(16'h0000, 16'h0080, 16'h0000, 8'h09, 1'b1),
            // keep nothing: list still emptied
            wr(REG_KEEP_COUNT, 16'h0000),
            pt(16'h1234, 16'h0300, 16'h0400, 8'h77, 1'b1),
            // out-of-range keep acts as full depth
            wr(REG_KEEP_COUNT, 16'h000F),
            pt(16'h0100, 16'hFE00, 16'h0100, 8'hC0, 1'b0),
            pt(16'h0101, 16'h0010, 16'hFFF0, 8'hC1, 1'b1),
            // keep one; a write to the unused address must not change it
            wr(REG_KEEP_COUNT, 16'h0001),
            wr(REG_UNUSED,     16'h0007),
            pt(16'h0200, 16'h0200, 16'h0200, 8'h3C, 1'b0),
            pt(16'h0201, 16'h0100, 16'h0100, 8'h3D, 1'b1),
            // distance is fixed on arrival: move the reference mid-batch
            wr(REG_KEEP_COUNT, 16'h0008),
            pt(16'h0007, 16'h0200, 16'h0000, 8'h70, 1'b0),
            wr(REG_REF_X,      16'h0200),
            pt(16'h0008, 16'h0200, 16'h0100, 8'h80, 1'b1)
        };

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_WRITE) begin
                wait_idle();
                reg_write(dir_tab[i].reg_idx, dir_tab[i].cfg_val);
            end else begin
                push_point(dir_tab[i].pnt, $urandom_range(0, 8), dir_tab[i].typed,
                           dir_tab[i].exp_dist);
            end
        end

        // Random phases. Each starts idle and may write fresh register values; batches
        // may straddle a phase, so reference moves also land mid-batch.
        sent       = 0;
        batch_left = $urandom_range(1, 10);
        while (sent < RAND_ITEMS) begin
            wait_idle();
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 5))
                    0:       pick = 16'h8000;
                    1:       pick = 16'h7FFF;
                    2:       pick = 16'h0000;
                    default: pick = 16'($urandom);
                endcase
                reg_write(REG_REF_X, pick);
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 5))
                    0:       pick = 16'h8000;
                    1:       pick = 16'h7FFF;
                    2:       pick = 16'h0000;
                    default: pick = 16'($urandom);
                endcase
                reg_write(REG_REF_Y, pick);
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 7))
                    0:       pick = 16'd0;
                    1:       pick = 16'd8;
                    2:       pick = 16'd15;
                    default: pick = 16'($urandom_range(0, 15));
                endcase
                reg_write(REG_KEEP_COUNT, pick);
            end
            tx_burst  = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(5, 40);
            for (int j = 0; j < phase_len && sent < RAND_ITEMS; j++) begin
                mode = $urandom_range(0, 9);
                p.tag  = 16'($urandom);
                p.x    = 16'($urandom);
                p.y    = 16'($urandom);
                p.conf = 8'($urandom);
                if (mode < 3) begin
                    // close to the reference on a coarse grid: ties and equal keys
                    p.tag = 16'($urandom_range(0, 3));
                    p.x   = cfg_ref_x + 16'((int'($urandom_range(0, 8)) - 4) * 64);
                    p.y   = cfg_ref_y + 16'((int'($urandom_range(0, 8)) - 4) * 64);
                end else if (mode == 3) begin
                    p.x = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                    p.y = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                end
                batch_left--;
                p.last = (batch_left == 0) || (sent == RAND_ITEMS - 1);
                if (batch_left == 0)
                    batch_left = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 20)
                                                             : $urandom_range(1, 10);
                push_point(p, tx_burst ? 0 : $urandom_range(0, 8), 1'b0, '0);
                sent++;
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: top_k_nearest_points.f
design/tknp_pkg.sv
design/tknp_ctrl.sv
design/tknp_dpath.sv
design/top_k_nearest_points.sv
tb/sv/top_k_nearest_points_tb.sv
